/* src/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Any property, sampled on the rising clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* src/fpsc_pkg.sv */
// ============================================================================
// Sine/cosine shared definitions
// Operation codes, field widths and the pi constant generator.
// ============================================================================
package fpsc_pkg;

    // Field widths of the stream words.
    localparam int ANGLE_W     = 32;
    localparam int VALUE_W     = 19;
    localparam int OUT_TDATA_W = 24;

    // Depth of the queue between range reduction and evaluation.
    localparam int QUEUE_DEPTH = 4;

    // pi scaled by 2^60, truncated.
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Operation selector carried in tuser.
    typedef enum logic {
        CMD_SINE = 1'b0,
        CMD_COS  = 1'b1
    } t_cmd;

    // pi * 2^frac / 2^e, rounded to nearest (e = -1 gives 2pi).
    function automatic logic [31:0] fpsc_pi_const(input int frac, input int e);
        int          sh;
        logic [63:0] v;
        sh = 60 - frac + e;
        v  = (PI_Q60 + (64'd1 << (sh - 1))) >> sh;
        return v[31:0];
    endfunction

endpackage

/* src/fpsc_queue.sv */
// ============================================================================
// Reduced-angle queue
// Small register FIFO that lets the front and back pipelines stall apart.
// ============================================================================
`include "assert_macros.svh"

module fpsc_queue #(
    parameter int WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import fpsc_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage words.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_CLK(a_q_cnt_max, r_cnt <= CNT_W'(DEPTH), "queue fill count above depth")
    `ASSERT_CLK(a_q_cnt_up, (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1), "queue count lost a push")

endmodule

/* src/fpsc_front.sv */
// ============================================================================
// Sine/cosine front end
// Accepts angles, applies the cosine offset and reduces modulo 2pi with one
// conditional subtract per pipeline stage.
// ============================================================================
`include "assert_macros.svh"

module fpsc_front #(
    parameter int FRAC_BITS = 17,
    parameter int X_W       = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  fpsc_pkg::t_cmd                  i_cmd,
    input  logic [fpsc_pkg::ANGLE_W-1:0]    i_angle,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [X_W-1:0]                  o_x
);
    import fpsc_pkg::*;

    localparam logic [31:0] TWO_PI   = fpsc_pi_const(FRAC_BITS, -1);
    localparam logic [31:0] HALF_OFS = fpsc_pi_const(FRAC_BITS, 0) >> 1;
    localparam int          CW       = $clog2(64'(TWO_PI) + 64'd1);
    localparam int          K        = 32 - CW;
    localparam int          NSTEP    = K + 1;

    logic [NSTEP:0] r_vld;
    logic [NSTEP:0] r_neg;
    logic [31:0]    r_mag [NSTEP + 1];
    logic           w_en;
    logic           w_acc;
    logic [31:0]    w_ang;
    logic [31:0]    w_fix;

    // 2pi shifted to the weight of a given step.
    function automatic logic [31:0] step_div(input int s);
        logic [63:0] d;
        d = 64'(TWO_PI) << (K - s);
        return d[31:0];
    endfunction

    assign w_en    = !r_vld[NSTEP] || i_ready;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;

    // Cosine offset with 32-bit wrap.
    assign w_ang = i_angle + ((i_cmd == CMD_COS) ? HALF_OFS : 32'd0);

    // Valid bits of the reduction pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld[0] <= w_acc;
            for (int s = 0; s < NSTEP; s++) begin
                r_vld[s + 1] <= r_vld[s];
            end
        end
    end

    // Sign and magnitude, then restoring subtraction of 2pi multiples.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg[0] <= w_ang[31];
            r_mag[0] <= w_ang[31] ? (32'd0 - w_ang) : w_ang;
            for (int s = 0; s < NSTEP; s++) begin
                r_neg[s + 1] <= r_neg[s];
                if (r_mag[s] >= step_div(s)) begin
                    r_mag[s + 1] <= r_mag[s] - step_div(s);
                end else begin
                    r_mag[s + 1] <= r_mag[s];
                end
            end
        end
    end

    // A negative remainder gets 2pi added.
    assign w_fix   = (r_neg[NSTEP] && (r_mag[NSTEP] != 32'd0)) ?
                     (TWO_PI - r_mag[NSTEP]) : r_mag[NSTEP];
    assign o_x     = w_fix[X_W-1:0];
    assign o_valid = r_vld[NSTEP];

    `ASSERT_IMPLY(a_fr_reduced, r_vld[NSTEP], r_mag[NSTEP] < TWO_PI, "remainder not below 2pi")

endmodule

/* src/fpsc_back.sv */
// ============================================================================
// Sine/cosine back end
// Folds the reduced angle into the first octant and evaluates the Horner
// polynomial, one multiply-subtract per stage, into the output register.
// ============================================================================
`include "assert_macros.svh"

module fpsc_back #(
    parameter int FRAC_BITS = 17,
    parameter int X_W       = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [X_W-1:0]                   i_x,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [fpsc_pkg::VALUE_W-1:0] o_value
);
    import fpsc_pkg::*;

    localparam logic [31:0] TWO_PI     = fpsc_pi_const(FRAC_BITS, -1);
    localparam logic [31:0] PI         = fpsc_pi_const(FRAC_BITS, 0);
    localparam logic [31:0] HALF_PI    = fpsc_pi_const(FRAC_BITS, 1);
    localparam logic [31:0] QUARTER_PI = fpsc_pi_const(FRAC_BITS, 2);

    localparam logic signed [31:0] ONE      = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] INV_2    = 32'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
    localparam logic signed [31:0] INV_6    = 32'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);
    localparam logic signed [31:0] INV_24   = 32'(((64'd1 << FRAC_BITS) + 64'd12) / 64'd24);
    localparam logic signed [31:0] INV_120  = 32'(((64'd1 << FRAC_BITS) + 64'd60) / 64'd120);
    localparam logic signed [31:0] INV_720  = 32'(((64'd1 << FRAC_BITS) + 64'd360) / 64'd720);
    localparam logic signed [31:0] INV_5040 = 32'(((64'd1 << FRAC_BITS) + 64'd2520) / 64'd5040);

    localparam logic signed [31:0] SAT_MAX = 32'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic signed [31:0] SAT_MIN = -SAT_MAX - 32'sd1;

    logic [7:1]   r_vld;
    logic [7:1]   r_neg;
    logic [6:3]   r_cos;
    logic         r_ovld;
    logic         w_en;

    logic [X_W-1:0]     r1_x;
    logic [X_W-1:0]     r2_x;
    logic [X_W-1:0]     r3_v;
    logic [X_W-1:0]     r4_v;
    logic [X_W-1:0]     r5_v;
    logic [X_W-1:0]     r6_v;
    logic signed [31:0] r4_v2;
    logic signed [31:0] r5_v2;
    logic signed [31:0] r5_v3;
    logic signed [31:0] r5_t1;
    logic signed [31:0] r6_v2;
    logic signed [31:0] r6_v3;
    logic signed [31:0] r6_t2;
    logic signed [31:0] r7_r;
    logic signed [VALUE_W-1:0] r_value;

    logic signed [31:0] w_v3s;
    logic signed [31:0] w_v4s;
    logic signed [31:0] w_v6s;
    logic signed [31:0] w_res;
    logic [31:0]        w_x2;

    // Fixed-point product: 64-bit product, floor shift, 32-bit wrap.
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[FRAC_BITS + 31:FRAC_BITS];
    endfunction

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign w_v3s   = $signed(32'(r3_v));
    assign w_v4s   = $signed(32'(r4_v));
    assign w_v6s   = $signed(32'(r6_v));
    assign w_x2    = 32'(r2_x);

    // Valid bits and the final output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[6:1], i_valid};
            r_ovld <= r_vld[7];
        end
    end

    // Symmetry folding down to [0, pi/4] and polynomial choice.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg[1] <= 32'(i_x) > PI;
            r1_x     <= (32'(i_x) > PI) ? X_W'(TWO_PI - 32'(i_x)) : i_x;

            r_neg[2] <= r_neg[1];
            r2_x     <= (32'(r1_x) > HALF_PI) ? X_W'(PI - 32'(r1_x)) : r1_x;

            r_neg[3] <= r_neg[2];
            r_cos[3] <= w_x2 > QUARTER_PI;
            r3_v     <= (w_x2 > QUARTER_PI) ? X_W'(HALF_PI - w_x2) : r2_x;
        end
    end

    // Horner evaluation, one multiply-subtract per stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg[4] <= r_neg[3];
            r_cos[4] <= r_cos[3];
            r4_v     <= r3_v;
            r4_v2    <= fmul(w_v3s, w_v3s);

            r_neg[5] <= r_neg[4];
            r_cos[5] <= r_cos[4];
            r5_v     <= r4_v;
            r5_v2    <= r4_v2;
            r5_v3    <= fmul(w_v4s, r4_v2);
            r5_t1    <= r_cos[4] ? (INV_24 - fmul(r4_v2, INV_720)) :
                                   (INV_120 - fmul(r4_v2, INV_5040));

            r_neg[6] <= r_neg[5];
            r_cos[6] <= r_cos[5];
            r6_v     <= r5_v;
            r6_v2    <= r5_v2;
            r6_v3    <= r5_v3;
            r6_t2    <= (r_cos[5] ? INV_2 : INV_6) - fmul(r5_v2, r5_t1);

            r_neg[7] <= r_neg[6];
            r7_r     <= (r_cos[6] ? ONE : w_v6s) -
                        fmul(r_cos[6] ? r6_v2 : r6_v3, r6_t2);
        end
    end

    // Sign restore and saturation into the output register.
    assign w_res = r_neg[7] ? (32'sd0 - r7_r) : r7_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_res > SAT_MAX) begin
                r_value <= SAT_MAX[VALUE_W-1:0];
            end else if (w_res < SAT_MIN) begin
                r_value <= SAT_MIN[VALUE_W-1:0];
            end else begin
                r_value <= w_res[VALUE_W-1:0];
            end
        end
    end

    assign o_valid = r_ovld;
    assign o_value = r_value;

    `ASSERT_IMPLY(a_bk_fold_range, r_vld[3], 32'(r3_v) <= QUARTER_PI + 32'd1, "fold above pi/4")

endmodule

/* src/fixed_point_sine_cosine.sv */
// ============================================================================
// Fixed-point sine and cosine
// Streaming sine/cosine of a signed fixed-point angle in radians.
// ============================================================================
// Usage:
//   Slave channel s_axis_*: one word per angle; tdata holds the angle,
//   tuser selects sine (0) or cosine (1). Master channel m_axis_*: one
//   word per angle, in order, tdata holds the 19-bit signed result.
//   Throughput is one angle per clock while m_axis_tready is high.
//   NSTEP = 33 - bits(2pi) is the number of subtract stages of the
//   modulo-2pi reduction; at FRAC_BITS = 17 that is 13 stages.
//   The reduction pipeline feeds a four-word queue; the evaluation
//   pipeline drains it into the output register. When m_axis_tready is
//   low the evaluation pipeline holds, the queue fills, and only then
//   does s_axis_tready drop. Synchronous reset empties every
//   pipeline stage and the queue; no other state is kept and no warm-up
//   is needed.
// ============================================================================
module fixed_point_sine_cosine #(
    parameter int FRAC_BITS = 17
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fpsc_pkg::ANGLE_W-1:0]         s_axis_tdata,  // [31:0] angle
    input  logic [0:0]                           s_axis_tuser,  // [0] cmd
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fpsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [18:0] value
);
    import fpsc_pkg::*;

    localparam logic [31:0] TWO_PI = fpsc_pi_const(FRAC_BITS, -1);
    localparam int          X_W    = $clog2(64'(TWO_PI));

    logic                      w_q_in_valid;
    logic                      w_q_in_ready;
    logic [X_W-1:0]            w_q_in_data;
    logic                      w_q_out_valid;
    logic                      w_q_out_ready;
    logic [X_W-1:0]            w_q_out_data;
    logic signed [VALUE_W-1:0] w_value;

    // Angle intake and modulo-2pi reduction.
    fpsc_front #(
        .FRAC_BITS (FRAC_BITS),
        .X_W       (X_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (t_cmd'(s_axis_tuser[0])),
        .i_angle (s_axis_tdata),
        .o_valid (w_q_in_valid),
        .i_ready (w_q_in_ready),
        .o_x     (w_q_in_data)
    );

    // Decoupling queue.
    fpsc_queue #(
        .WIDTH (X_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_in_valid),
        .o_ready (w_q_in_ready),
        .i_data  (w_q_in_data),
        .o_valid (w_q_out_valid),
        .i_ready (w_q_out_ready),
        .o_data  (w_q_out_data)
    );

    // Folding and polynomial evaluation.
    fpsc_back #(
        .FRAC_BITS (FRAC_BITS),
        .X_W       (X_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_out_valid),
        .o_ready (w_q_out_ready),
        .i_x     (w_q_out_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (w_value)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - VALUE_W){1'b0}}, w_value};

endmodule
